FILE: sv/ile_pkg.sv
// Shared constants, field layout and operation codes of the indexed list engine.
package ile_pkg;

    // Default sizing
    localparam int ILE_CAPACITY = 16;
    localparam int ILE_DATA_W   = 32;

    // Field widths of one transaction
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int WIDE_W  = 64;

    // Slave-side tdata: mode, index, value from bit 0 up, padded to 48 bits
    localparam int S_MODE_LSB  = 0;
    localparam int S_INDEX_LSB = S_MODE_LSB + MODE_W;
    localparam int S_VALUE_LSB = S_INDEX_LSB + INDEX_W;
    localparam int S_USED_W    = S_VALUE_LSB + VALUE_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // Master-side tdata: ok, value_out, position, count from bit 0 up, padded to 48 bits
    localparam int M_OK_LSB    = 0;
    localparam int M_VALUE_LSB = M_OK_LSB + 1;
    localparam int M_POS_LSB   = M_VALUE_LSB + VALUE_W;
    localparam int M_COUNT_LSB = M_POS_LSB + POS_W;
    localparam int M_USED_W    = M_COUNT_LSB + COUNT_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // Operation codes; the remaining code does nothing and fails
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_GET    = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_POP    = 3'd3,
        MODE_FIND   = 3'd4,
        MODE_ADDU   = 3'd5,
        MODE_REMOVE = 3'd6
    } t_mode;

endpackage

FILE: sv/indexed_list_engine_core.sv
// Top level of the indexed list engine: operation sequencer, entry store and result register.
// Ordered list of up to CAPACITY words kept in a single-port-read, single-port-write memory,
// with a stream transaction in and one result transaction out per operation. One operation
// is worked at a time; the next is taken as soon as the previous result has been handed to
// the output register, even while that result still waits for the sink. Append and get move
// no entries; find and add unique scan the list from the front; insert at the end writes
// directly, elsewhere it first moves the entries from the position on up by one; pop moves
// the entries above the target down unless the top entry goes; remove scans and then moves.
// An out-of-range get, pop or insert fails without a memory access, and a pop of a null
// entry fails after its read. Moves and searches run at the rate of the memory, which gives
// one read and one write per cycle. Entries need no clearing after reset and the block is
// ready at once.
module indexed_list_engine_core #(
    parameter int CAPACITY   = ile_pkg::ILE_CAPACITY,
    parameter int DATA_WIDTH = ile_pkg::ILE_DATA_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // mode[2:0], index[8:3], value[40:9], zero pad above
    input  logic [ile_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // ok[0], value_out[32:1], position[37:33], count[42:38], zero pad above
    output logic [ile_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import ile_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int RW = ((LW > INDEX_W) ? LW : INDEX_W) + 2;
    localparam int DW = DATA_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GET_WAIT,
        ST_POP_CHK,
        ST_SCAN,
        ST_TAKE,
        ST_SHIFT,
        ST_DRAIN,
        ST_INS_PUT,
        ST_RESP
    } t_state;

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic signed [INDEX_W-1:0] r_idx, n_idx;
    logic [DW-1:0]         r_val, n_val;
    logic [LW-1:0]         r_len, n_len;
    logic [LW-1:0]         r_ptr, n_ptr;
    logic [LW-1:0]         r_end, n_end;
    logic                  r_up, n_up;
    logic                  r_wpend, n_wpend;
    logic [AW-1:0]         r_waddr, n_waddr;
    logic [AW-1:0]         r_tgt, n_tgt;
    logic                  r_cmp_v, n_cmp_v;
    logic [AW-1:0]         r_cmp_idx, n_cmp_idx;
    logic                  r_ok, n_ok;
    logic [DW-1:0]         r_vout, n_vout;
    logic                  r_found, n_found;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data, n_out_data;

    // Memory port controls
    logic                  m_we;
    logic [AW-1:0]         m_waddr;
    logic [DW-1:0]         m_wdata;
    logic                  m_re;
    logic [AW-1:0]         m_raddr;
    logic [DW-1:0]         m_rdata;

    // Index resolution and range checks
    logic signed [RW-1:0]  idx_s, len_s, res_s;
    logic                  get_rng, ins_rng, not_full;
    logic [AW-1:0]         res_addr, len_addr;
    logic [LW-1:0]         tgt_next;

    // Field conversions
    logic [WIDE_W-1:0]     in_val_wide, vout_wide, pos_wide, len_wide;
    logic [POS_W-1:0]      pos_field;
    logic                  hit, accept;

    assign idx_s    = RW'(r_idx);
    assign len_s    = RW'({1'b0, r_len});
    assign res_s    = idx_s[RW-1] ? (len_s + idx_s) : idx_s;
    assign get_rng  = !res_s[RW-1] && (res_s < len_s);
    assign ins_rng  = !res_s[RW-1] && (res_s <= len_s);
    assign not_full = r_len < LW'(CAPACITY);
    assign res_addr = res_s[AW-1:0];
    assign len_addr = r_len[AW-1:0];
    assign tgt_next = LW'(r_tgt) + 1'b1;

    assign in_val_wide = WIDE_W'(i_s_tdata[S_VALUE_LSB +: VALUE_W]);
    assign vout_wide   = WIDE_W'(r_vout);
    assign pos_wide    = WIDE_W'(r_pos);
    assign len_wide    = WIDE_W'(n_len);
    assign pos_field   = r_found ? pos_wide[POS_W-1:0] : '1;

    assign hit    = r_cmp_v && (m_rdata == r_val);
    assign accept = i_s_tvalid && o_s_tready;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    ile_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DW),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // Sequencer next state and memory accesses
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_val       = r_val;
        n_len       = r_len;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_up        = r_up;
        n_wpend     = r_wpend;
        n_waddr     = r_waddr;
        n_tgt       = r_tgt;
        n_cmp_v     = r_cmp_v;
        n_cmp_idx   = r_cmp_idx;
        n_ok        = r_ok;
        n_vout      = r_vout;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        m_we        = 1'b0;
        m_waddr     = len_addr;
        m_wdata     = r_val;
        m_re        = 1'b0;
        m_raddr     = res_addr;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode  = i_s_tdata[S_MODE_LSB +: MODE_W];
                    n_idx   = i_s_tdata[S_INDEX_LSB +: INDEX_W];
                    n_val   = in_val_wide[DW-1:0];
                    n_ok    = 1'b0;
                    n_vout  = '0;
                    n_found = 1'b0;
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_RESP;
                case (r_mode)
                    MODE_APPEND: begin
                        if (not_full) begin
                            m_we   = 1'b1;
                            n_len  = r_len + 1'b1;
                            n_ok   = 1'b1;
                            n_vout = r_val;
                        end
                    end
                    MODE_GET: begin
                        if (get_rng) begin
                            m_re    = 1'b1;
                            n_state = ST_GET_WAIT;
                        end
                    end
                    MODE_INSERT: begin
                        if (ins_rng && not_full) begin
                            n_tgt = res_addr;
                            if (res_s == len_s) begin
                                n_state = ST_INS_PUT;
                            end else begin
                                n_ptr   = r_len - 1'b1;
                                n_end   = res_s[LW-1:0];
                                n_up    = 1'b1;
                                n_wpend = 1'b0;
                                n_state = ST_SHIFT;
                            end
                        end
                    end
                    MODE_POP: begin
                        if (get_rng) begin
                            m_re    = 1'b1;
                            n_tgt   = res_addr;
                            n_state = ST_POP_CHK;
                        end
                    end
                    MODE_FIND, MODE_ADDU, MODE_REMOVE: begin
                        n_ptr   = '0;
                        n_cmp_v = 1'b0;
                        n_state = ST_SCAN;
                    end
                    default: begin
                        n_state = ST_RESP;
                    end
                endcase
            end

            // Null entries fail a get
            ST_GET_WAIT: begin
                if (m_rdata != '0) begin
                    n_ok   = 1'b1;
                    n_vout = m_rdata;
                end
                n_state = ST_RESP;
            end

            ST_POP_CHK: begin
                if (m_rdata != '0) begin
                    n_ok    = 1'b1;
                    n_vout  = m_rdata;
                    n_state = ST_TAKE;
                end else begin
                    n_state = ST_RESP;
                end
            end

            // Linear search: one read issued and one compare done per cycle
            ST_SCAN: begin
                m_raddr = r_ptr[AW-1:0];
                if (hit) begin
                    n_found = 1'b1;
                    n_pos   = r_cmp_idx;
                    n_state = ST_RESP;
                    case (r_mode)
                        MODE_FIND: begin
                            n_ok   = 1'b1;
                            n_vout = r_val;
                        end
                        MODE_REMOVE: begin
                            if (r_val != '0) begin
                                n_ok    = 1'b1;
                                n_vout  = r_val;
                                n_tgt   = r_cmp_idx;
                                n_state = ST_TAKE;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end else if (r_ptr < r_len) begin
                    m_re      = 1'b1;
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + 1'b1;
                end else begin
                    // Miss; add unique then appends if the list is not full
                    n_state = ST_RESP;
                    if ((r_mode == MODE_ADDU) && not_full) begin
                        m_we   = 1'b1;
                        n_len  = r_len + 1'b1;
                        n_ok   = 1'b1;
                        n_vout = r_val;
                    end
                end
            end

            // Close the gap at the target by moving the entries above it down
            ST_TAKE: begin
                if (tgt_next < r_len) begin
                    n_ptr   = tgt_next;
                    n_end   = r_len - 1'b1;
                    n_up    = 1'b0;
                    n_wpend = 1'b0;
                    n_state = ST_SHIFT;
                end else begin
                    n_len   = r_len - 1'b1;
                    n_state = ST_RESP;
                end
            end

            // Pipelined move: read one entry while writing the one read before
            ST_SHIFT: begin
                m_we    = r_wpend;
                m_waddr = r_waddr;
                m_wdata = m_rdata;
                m_re    = 1'b1;
                m_raddr = r_ptr[AW-1:0];
                n_wpend = 1'b1;
                n_waddr = r_up ? (r_ptr[AW-1:0] + 1'b1) : (r_ptr[AW-1:0] - 1'b1);
                if (r_ptr == r_end) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_ptr = r_up ? (r_ptr - 1'b1) : (r_ptr + 1'b1);
                end
            end

            ST_DRAIN: begin
                m_we    = 1'b1;
                m_waddr = r_waddr;
                m_wdata = m_rdata;
                n_wpend = 1'b0;
                if (r_up) begin
                    n_state = ST_INS_PUT;
                end else begin
                    n_len   = r_len - 1'b1;
                    n_state = ST_RESP;
                end
            end

            ST_INS_PUT: begin
                m_we    = 1'b1;
                m_waddr = r_tgt;
                n_len   = r_len + 1'b1;
                n_ok    = 1'b1;
                n_vout  = r_val;
                n_state = ST_RESP;
            end

            // Hand the result to the output register once it is free
            ST_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_data[M_OK_LSB]                = r_ok;
                    n_out_data[M_VALUE_LSB +: VALUE_W]  = vout_wide[VALUE_W-1:0];
                    n_out_data[M_POS_LSB +: POS_W]      = pos_field;
                    n_out_data[M_COUNT_LSB +: COUNT_W]  = len_wide[COUNT_W-1:0];
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_wpend     <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_wpend     <= n_wpend;
            r_cmp_v     <= n_cmp_v;
            r_out_valid <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_ptr      <= n_ptr;
        r_end      <= n_end;
        r_up       <= n_up;
        r_waddr    <= n_waddr;
        r_tgt      <= n_tgt;
        r_cmp_idx  <= n_cmp_idx;
        r_ok       <= n_ok;
        r_vout     <= n_vout;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_out_data <= n_out_data;
    end

endmodule

FILE: sv/ile_mem.sv
// Entry store of the list: one write port, one read port, registered read data.
module ile_mem #(
    parameter int DEPTH = ile_pkg::ILE_CAPACITY,
    parameter int WIDTH = ile_pkg::ILE_DATA_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data, held while no read is enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/ile_chk.sv
// Port-level checks of the indexed list engine and their bind to the top level.
module ile_chk #(
    parameter int CAPACITY = ile_pkg::ILE_CAPACITY
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ile_pkg::M_TDATA_W-1:0] o_m_tdata
);

    import ile_pkg::*;

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // One operation at a time: a new transaction closes the slave side
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("slave side still ready after a transaction");

    // A failed operation returns a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[M_OK_LSB]) |-> (o_m_tdata[M_VALUE_LSB +: VALUE_W] == '0))
        else $error("failed operation with non-zero value");

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (CAPACITY < 32)) |->
            (o_m_tdata[M_COUNT_LSB +: COUNT_W] <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind indexed_list_engine_core ile_chk #(.CAPACITY(CAPACITY)) u_ile_chk (.*);
